### rtl/bisection_cubic_root_finder_unit_macros.svh
// Assertion macros shared by the root finder RTL.
`ifndef BISECTION_CUBIC_ROOT_FINDER_UNIT_MACROS_SVH
`define BISECTION_CUBIC_ROOT_FINDER_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BCRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BCRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bcrf_pkg.sv
package bcrf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int TOL_W     = 16;
    localparam int LIMIT_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 3;
    localparam int PDATA_W   = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

    // Register index, taken from the word address bit.
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_ITER_LIMIT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

    typedef struct packed {
        logic [TOL_W-1:0]   tolerance;
        logic [LIMIT_W-1:0] iteration_limit;
    } cfg_t;

endpackage

### rtl/bcrf_cfg.sv
module bcrf_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bcrf_pkg::ADDR_W-1:0]      paddr,
    input  logic [bcrf_pkg::PDATA_W-1:0]     pwdata,
    output logic [bcrf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output bcrf_pkg::cfg_t                   cfg
);

    logic [bcrf_pkg::TOL_W-1:0]   tolerance_reg;
    logic [bcrf_pkg::LIMIT_W-1:0] limit_reg;
    logic                         wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= bcrf_pkg::TOL_RESET;
            limit_reg     <= bcrf_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bcrf_pkg::REG_TOLERANCE:
                    tolerance_reg <= pwdata[bcrf_pkg::TOL_W-1:0];
                bcrf_pkg::REG_ITER_LIMIT:
                    limit_reg <= pwdata[bcrf_pkg::LIMIT_W-1:0];
                default:
                    limit_reg <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bcrf_pkg::REG_TOLERANCE:
                prdata = {{(bcrf_pkg::PDATA_W-bcrf_pkg::TOL_W){1'b0}}, tolerance_reg};
            bcrf_pkg::REG_ITER_LIMIT:
                prdata = {{(bcrf_pkg::PDATA_W-bcrf_pkg::LIMIT_W){1'b0}}, limit_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.tolerance       = tolerance_reg;
    assign cfg.iteration_limit = limit_reg;

endmodule

### rtl/bcrf_cubic.sv
module bcrf_cubic #(
    parameter int FRAC_BITS = bcrf_pkg::FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [bcrf_pkg::DATA_W-1:0] x,
    output logic                               done,
    output logic signed [bcrf_pkg::DATA_W-1:0] f
);

    localparam int X2_W = bcrf_pkg::DATA_W - 1;
    localparam logic signed [bcrf_pkg::PROD_W-1:0] TEN_FX =
        64'sd10 <<< FRAC_BITS;

    typedef enum logic [2:0] {
        IDLE,
        MUL_SQ,
        SCALE,
        MUL_CUBE,
        SUM
    } state_t;

    state_t                                state_reg;
    logic signed [bcrf_pkg::DATA_W-1:0]    x_reg;
    logic signed [bcrf_pkg::DATA_W-1:0]    op_a_reg;
    logic signed [bcrf_pkg::DATA_W-1:0]    op_b_reg;
    logic signed [bcrf_pkg::PROD_W-1:0]    prod_reg;
    logic [X2_W-1:0]                       x2_reg;
    logic [X2_W-1:0]                       x2_next;
    logic signed [bcrf_pkg::PROD_W-1:0]    sum_wide;

    // The square is never negative, so the shifted value saturates on any high bit.
    always_comb
    begin
        if (|prod_reg[bcrf_pkg::PROD_W-1:FRAC_BITS+X2_W])
            x2_next = '1;
        else
            x2_next = prod_reg[FRAC_BITS+X2_W-1:FRAC_BITS];
    end

    assign sum_wide = (prod_reg >>> FRAC_BITS)
                    + $signed({{(bcrf_pkg::PROD_W-X2_W-2){1'b0}}, x2_reg, 2'b00})
                    - TEN_FX;

    always_comb
    begin
        if (sum_wide[bcrf_pkg::PROD_W-1] &&
            !(&sum_wide[bcrf_pkg::PROD_W-2:bcrf_pkg::DATA_W-1]))
            f = {1'b1, {(bcrf_pkg::DATA_W-1){1'b0}}};
        else if (!sum_wide[bcrf_pkg::PROD_W-1] &&
                 (|sum_wide[bcrf_pkg::PROD_W-2:bcrf_pkg::DATA_W-1]))
            f = {1'b0, {(bcrf_pkg::DATA_W-1){1'b1}}};
        else
            f = sum_wide[bcrf_pkg::DATA_W-1:0];
    end

    assign done = (state_reg == SUM);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a_reg * op_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x;
                        op_a_reg  <= x;
                        op_b_reg  <= x;
                        state_reg <= MUL_SQ;
                    end
                end
                MUL_SQ:
                begin
                    state_reg <= SCALE;
                end
                SCALE:
                begin
                    x2_reg    <= x2_next;
                    op_a_reg  <= $signed({1'b0, x2_next});
                    op_b_reg  <= x_reg;
                    state_reg <= MUL_CUBE;
                end
                MUL_CUBE:
                begin
                    state_reg <= SUM;
                end
                SUM:
                begin
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/bisection_cubic_root_finder_unit.sv
// Channel   Handshake                 Payload
// input     in_valid / in_ready       lower_end, upper_end
// output    out_valid / out_ready     root, status, iterations_used
// config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// An item with lower_end >= upper_end is answered in the cycle after it is accepted.
// Otherwise the cubic is evaluated at the lower end and then once per bisection
// step, on the shared 32x32 multiplier that each evaluation uses twice.
// The block takes one item at a time; in_ready is high only while it is idle.
// Reset returns to idle with tolerance 1 and iteration limit 100.
`include "bisection_cubic_root_finder_unit_macros.svh"

module bisection_cubic_root_finder_unit #(
    parameter int FRAC_BITS = bcrf_pkg::FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [bcrf_pkg::DATA_W-1:0]   lower_end,
    input  logic signed [bcrf_pkg::DATA_W-1:0]   upper_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bcrf_pkg::DATA_W-1:0]   root,
    output logic [bcrf_pkg::STATUS_W-1:0]        status,
    output logic [bcrf_pkg::LIMIT_W-1:0]         iterations_used,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bcrf_pkg::ADDR_W-1:0]          paddr,
    input  logic [bcrf_pkg::PDATA_W-1:0]         pwdata,
    output logic [bcrf_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int W = bcrf_pkg::DATA_W;

    typedef enum logic [2:0] {
        IDLE,
        WAIT_A,
        MID,
        WAIT_C,
        UPDATE,
        OUT
    } state_t;

    state_t                      state_reg;
    bcrf_pkg::cfg_t              cfg;
    logic signed [W-1:0]         a_reg;
    logic signed [W-1:0]         b_reg;
    logic signed [W-1:0]         c_reg;
    logic signed [W-1:0]         prev_reg;
    logic signed [W-1:0]         fc_reg;
    logic                        fa_pos_reg;
    logic                        fa_neg_reg;
    logic                        have_prev_reg;
    logic [bcrf_pkg::LIMIT_W-1:0] iter_reg;
    logic signed [W-1:0]         root_reg;
    logic [bcrf_pkg::STATUS_W-1:0] status_reg;
    logic [bcrf_pkg::LIMIT_W-1:0] iters_reg;

    logic                        in_fire;
    logic                        cub_start;
    logic signed [W-1:0]         cub_x;
    logic                        cub_done;
    logic signed [W-1:0]         cub_f;
    logic [W:0]                  span;
    logic signed [W-1:0]         c_next;
    logic [bcrf_pkg::LIMIT_W-1:0] limit_eff;
    logic signed [W:0]           step;
    logic signed [W:0]           tol_ext;
    logic [W:0]                  mag;
    logic                        same_sign;
    logic                        converged;

    bcrf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcrf_cubic #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cubic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cub_start),
        .x     (cub_x),
        .done  (cub_done),
        .f     (cub_f)
    );

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = (state_reg == OUT);
    assign in_fire   = in_valid && in_ready;

    // The span b - a is positive and below 2^32, so its half fits in W - 1 bits.
    assign span   = {b_reg[W-1], b_reg} - {a_reg[W-1], a_reg};
    assign c_next = a_reg + $signed(span[W:1]);

    assign cub_start = (in_fire && (lower_end < upper_end)) || (state_reg == MID);
    assign cub_x     = (state_reg == MID) ? c_next : lower_end;

    assign limit_eff = (cfg.iteration_limit == '0) ? bcrf_pkg::LIMIT_W'(1)
                                                   : cfg.iteration_limit;

    assign tol_ext   = $signed({{(W+1-bcrf_pkg::TOL_W){1'b0}}, cfg.tolerance});
    assign step      = {c_reg[W-1], c_reg} - {prev_reg[W-1], prev_reg};
    assign mag       = fc_reg[W-1] ? -{fc_reg[W-1], fc_reg} : {fc_reg[W-1], fc_reg};
    assign same_sign = (fa_pos_reg && !fc_reg[W-1] && (fc_reg != '0)) ||
                       (fa_neg_reg && fc_reg[W-1]);
    assign converged = have_prev_reg && (step <= tol_ext) && (step >= -tol_ext) &&
                       (mag <= $unsigned(tol_ext));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (in_fire)
                    begin
                        if (lower_end >= upper_end)
                        begin
                            root_reg   <= '0;
                            status_reg <= bcrf_pkg::ST_INVALID;
                            iters_reg  <= '0;
                            state_reg  <= OUT;
                        end
                        else
                        begin
                            a_reg         <= lower_end;
                            b_reg         <= upper_end;
                            iter_reg      <= '0;
                            have_prev_reg <= 1'b0;
                            state_reg     <= WAIT_A;
                        end
                    end
                end
                WAIT_A:
                begin
                    if (cub_done)
                    begin
                        fa_pos_reg <= !cub_f[W-1] && (cub_f != '0);
                        fa_neg_reg <= cub_f[W-1];
                        state_reg  <= MID;
                    end
                end
                MID:
                begin
                    c_reg     <= c_next;
                    iter_reg  <= iter_reg + 1'b1;
                    state_reg <= WAIT_C;
                end
                WAIT_C:
                begin
                    if (cub_done)
                    begin
                        fc_reg    <= cub_f;
                        state_reg <= UPDATE;
                    end
                end
                UPDATE:
                begin
                    if (same_sign)
                    begin
                        a_reg      <= c_reg;
                        fa_pos_reg <= !fc_reg[W-1] && (fc_reg != '0);
                        fa_neg_reg <= fc_reg[W-1];
                    end
                    else
                    begin
                        b_reg <= c_reg;
                    end
                    prev_reg      <= c_reg;
                    have_prev_reg <= 1'b1;
                    if (converged)
                    begin
                        root_reg   <= c_reg;
                        status_reg <= bcrf_pkg::ST_CONVERGED;
                        iters_reg  <= iter_reg;
                        state_reg  <= OUT;
                    end
                    else if (iter_reg == limit_eff)
                    begin
                        root_reg   <= c_reg;
                        status_reg <= bcrf_pkg::ST_LIMIT;
                        iters_reg  <= limit_eff;
                        state_reg  <= OUT;
                    end
                    else
                    begin
                        state_reg <= MID;
                    end
                end
                OUT:
                begin
                    if (out_ready)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign root            = root_reg;
    assign status          = status_reg;
    assign iterations_used = iters_reg;

    `BCRF_ASSERT(a_no_overlap, !(in_ready && out_valid), "Input and output sides both open")
    `BCRF_ASSERT(a_invalid_fields, (out_valid && status == bcrf_pkg::ST_INVALID) |-> (iterations_used == '0 && root == '0), "Invalid interval result carries data")
    `BCRF_ASSERT(a_limit_count, (out_valid && status == bcrf_pkg::ST_LIMIT) |-> (iterations_used == limit_eff), "Limit result has wrong iteration count")
    `BCRF_ASSERT(a_done_waited, cub_done |-> (state_reg == WAIT_A || state_reg == WAIT_C), "Cubic result arrived while not awaited")
    `BCRF_ASSERT(a_iter_bound, (state_reg == UPDATE) |-> (iter_reg != '0 && iter_reg <= limit_eff), "Iteration count out of range")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic signed [bcrf_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [bcrf_pkg::DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [bcrf_pkg::DATA_W-1:0] ONE_Q   = 32'sd65536;
    localparam logic signed [bcrf_pkg::DATA_W-1:0] ROOT_Q  = 32'sd89472;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 20;

    typedef struct {
        logic signed [bcrf_pkg::DATA_W-1:0] root;
        logic [bcrf_pkg::STATUS_W-1:0]      status;
        logic [bcrf_pkg::LIMIT_W-1:0]       iterations;
    } root_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [bcrf_pkg::DATA_W-1:0]   lower_end = '0;
    logic signed [bcrf_pkg::DATA_W-1:0]   upper_end = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [bcrf_pkg::DATA_W-1:0]   root;
    logic [bcrf_pkg::STATUS_W-1:0]        status;
    logic [bcrf_pkg::LIMIT_W-1:0]         iterations_used;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [bcrf_pkg::ADDR_W-1:0]          paddr = '0;
    logic [bcrf_pkg::PDATA_W-1:0]         pwdata = '0;
    logic [bcrf_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;

    logic [bcrf_pkg::TOL_W-1:0]           tol_setting = bcrf_pkg::TOL_RESET;
    logic [bcrf_pkg::LIMIT_W-1:0]         limit_setting = bcrf_pkg::LIMIT_RESET;
    root_result_t                         pending_results[$];
    root_result_t                         oldest_result;
    int                                   error_count = 0;
    int unsigned                          idle_cycles = 0;
    int unsigned                          ready_hold = 0;

    bisection_cubic_root_finder_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .lower_end       (lower_end),
        .upper_end       (upper_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .root            (root),
        .status          (status),
        .iterations_used (iterations_used),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [bcrf_pkg::PROD_W-1:0] cubic_q(
        input logic signed [bcrf_pkg::PROD_W-1:0] x);
        logic signed [bcrf_pkg::PROD_W-1:0] sq;
        logic signed [bcrf_pkg::PROD_W-1:0] cube;
        logic signed [bcrf_pkg::PROD_W-1:0] sum;
        sq = (x * x) >>> bcrf_pkg::FRAC_BITS;
        if (sq > 64'sd2147483647)
            sq = 64'sd2147483647;
        cube = (sq * x) >>> bcrf_pkg::FRAC_BITS;
        sum = cube + 4 * sq - (64'sd10 <<< bcrf_pkg::FRAC_BITS);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        else if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum;
    endfunction

    function automatic root_result_t bisect_interval(
        input logic signed [bcrf_pkg::DATA_W-1:0] lo,
        input logic signed [bcrf_pkg::DATA_W-1:0] hi,
        input logic [bcrf_pkg::TOL_W-1:0] tol,
        input logic [bcrf_pkg::LIMIT_W-1:0] limit_reg);
        logic signed [bcrf_pkg::PROD_W-1:0] a;
        logic signed [bcrf_pkg::PROD_W-1:0] b;
        logic signed [bcrf_pkg::PROD_W-1:0] c;
        logic signed [bcrf_pkg::PROD_W-1:0] prev;
        logic signed [bcrf_pkg::PROD_W-1:0] fa;
        logic signed [bcrf_pkg::PROD_W-1:0] fc;
        logic signed [bcrf_pkg::PROD_W-1:0] step_abs;
        logic signed [bcrf_pkg::PROD_W-1:0] mag;
        logic signed [bcrf_pkg::PROD_W-1:0] tol_s;
        int unsigned limit;
        int unsigned i;
        bit have_prev;
        root_result_t r;
        a = bcrf_pkg::PROD_W'(lo);
        b = bcrf_pkg::PROD_W'(hi);
        tol_s = bcrf_pkg::PROD_W'(tol);
        limit = (limit_reg == 0) ? 1 : limit_reg;
        if (a >= b)
        begin
            r.root = '0;
            r.status = bcrf_pkg::ST_INVALID;
            r.iterations = '0;
            return r;
        end
        c = 0;
        prev = 0;
        have_prev = 1'b0;
        for (i = 1; i <= limit; i++)
        begin
            c = a + ((b - a) >>> 1);
            fa = cubic_q(a);
            fc = cubic_q(c);
            if ((fa > 0 && fc > 0) || (fa < 0 && fc < 0))
                a = c;
            else
                b = c;
            step_abs = c - prev;
            if (step_abs < 0)
                step_abs = -step_abs;
            mag = (fc < 0) ? -fc : fc;
            if (have_prev && step_abs <= tol_s && mag <= tol_s)
            begin
                r.root = c[bcrf_pkg::DATA_W-1:0];
                r.status = bcrf_pkg::ST_CONVERGED;
                r.iterations = i[bcrf_pkg::LIMIT_W-1:0];
                return r;
            end
            prev = c;
            have_prev = 1'b1;
        end
        r.root = c[bcrf_pkg::DATA_W-1:0];
        r.status = bcrf_pkg::ST_LIMIT;
        r.iterations = limit[bcrf_pkg::LIMIT_W-1:0];
        return r;
    endfunction

    task automatic send_interval(input logic signed [bcrf_pkg::DATA_W-1:0] lo,
                                 input logic signed [bcrf_pkg::DATA_W-1:0] hi);
        int unsigned gap;
        in_valid <= 1'b1;
        lower_end <= lo;
        upper_end <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(bisect_interval(lo, hi, tol_setting, limit_setting));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic reg_index,
                                  input logic [bcrf_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (reg_index == bcrf_pkg::REG_TOLERANCE)
            tol_setting = value[bcrf_pkg::TOL_W-1:0];
        else
            limit_setting = value[bcrf_pkg::LIMIT_W-1:0];
    endtask

    task automatic check_register(input logic reg_index,
                                  input logic [bcrf_pkg::PDATA_W-1:0] want);
        logic [bcrf_pkg::PDATA_W-1:0] got;
        logic bad;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (reg_index == bcrf_pkg::REG_TOLERANCE)
            bad = got[bcrf_pkg::TOL_W-1:0] !== want[bcrf_pkg::TOL_W-1:0];
        else
            bad = got[bcrf_pkg::LIMIT_W-1:0] !== want[bcrf_pkg::LIMIT_W-1:0];
        if (bad)
        begin
            $display("%0t: register %0d expected %0d actual %0d", $time, reg_index, want, got);
            error_count++;
        end
    endtask

    task automatic configure(input logic [bcrf_pkg::TOL_W-1:0] tol,
                             input logic [bcrf_pkg::LIMIT_W-1:0] limit);
        wait_for_results();
        write_register(bcrf_pkg::REG_TOLERANCE,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::TOL_W){1'b0}}, tol});
        write_register(bcrf_pkg::REG_ITER_LIMIT,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::LIMIT_W){1'b0}}, limit});
        check_register(bcrf_pkg::REG_TOLERANCE,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::TOL_W){1'b0}}, tol});
        check_register(bcrf_pkg::REG_ITER_LIMIT,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::LIMIT_W){1'b0}}, limit});
    endtask

    task automatic test_reset_settings();
        check_register(bcrf_pkg::REG_TOLERANCE,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::TOL_W){1'b0}}, bcrf_pkg::TOL_RESET});
        check_register(bcrf_pkg::REG_ITER_LIMIT,
                       {{(bcrf_pkg::PDATA_W-bcrf_pkg::LIMIT_W){1'b0}}, bcrf_pkg::LIMIT_RESET});
        send_interval(ONE_Q, 2 * ONE_Q);
        send_interval(0, 0);
        send_interval(2 * ONE_Q, ONE_Q);
        send_interval(INT_MIN, INT_MAX);
        send_interval(INT_MAX, INT_MIN);
        send_interval(INT_MIN, INT_MIN + 1);
        send_interval(INT_MAX - 1, INT_MAX);
        send_interval(-4 * ONE_Q, 0);
        send_interval(-1, 0);
    endtask

    task automatic test_iteration_limits();
        configure(16'hFFFF, 8'd1);
        send_interval(ONE_Q, 2 * ONE_Q);
        configure(16'hFFFF, 8'd0);
        send_interval(ONE_Q, 2 * ONE_Q);
        configure(16'hFFFF, 8'd2);
        send_interval(32'sd89000, 32'sd90000);
        configure(16'hFFFF, 8'd255);
        send_interval(INT_MIN, INT_MAX);
        configure(16'd0, 8'd255);
        send_interval(ONE_Q, 2 * ONE_Q);
        send_interval(INT_MIN, INT_MAX);
    endtask

    task automatic send_random_interval();
        logic signed [bcrf_pkg::DATA_W-1:0] lo;
        logic signed [bcrf_pkg::DATA_W-1:0] hi;
        logic [bcrf_pkg::DATA_W-1:0] span;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        span = $urandom >> $urandom_range(0, 31);
        if (pick < 60)
        begin
            lo = ROOT_Q - ($urandom >> $urandom_range(1, 31));
            hi = ROOT_Q + ($urandom >> $urandom_range(2, 31));
        end
        else if (pick < 75)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (pick < 90)
        begin
            lo = $urandom;
            hi = lo + span;
        end
        else if (pick < 95)
        begin
            lo = $urandom;
            hi = lo;
        end
        else
        begin
            lo = $urandom;
            hi = lo - span;
        end
        send_interval(lo, hi);
    endtask

    task automatic test_random_intervals();
        int unsigned phase;
        int unsigned n;
        int unsigned count;
        logic [bcrf_pkg::TOL_W-1:0] tol;
        logic [bcrf_pkg::LIMIT_W-1:0] limit;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: tol = bcrf_pkg::TOL_W'($urandom_range(0, 3));
                1: tol = bcrf_pkg::TOL_W'($urandom);
                2: tol = 16'hFFFF;
                default: tol = bcrf_pkg::TOL_W'($urandom_range(0, 2047));
            endcase
            limit = (phase == 7) ? bcrf_pkg::LIMIT_W'($urandom_range(200, 255))
                                 : bcrf_pkg::LIMIT_W'($urandom_range(1, 40));
            count = (phase == 7) ? 80 : 215;
            configure(tol, limit);
            for (n = 0; n < count; n++)
            begin
                send_random_interval();
                if ($urandom_range(0, 59) == 0)
                    wait_for_results();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            ready_hold <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
            ready_hold <= ($urandom_range(0, 99) < 10) ? $urandom_range(100, 400)
                                                       : $urandom_range(0, 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no item pending: root %0d status %0d iterations %0d",
                         $time, root, status, iterations_used);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (root !== oldest_result.root)
                begin
                    $display("%0t: root expected %0d actual %0d",
                             $time, oldest_result.root, root);
                    error_count++;
                end
                if (status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_result.status, status);
                    error_count++;
                end
                if (iterations_used !== oldest_result.iterations)
                begin
                    $display("%0t: iterations expected %0d actual %0d",
                             $time, oldest_result.iterations, iterations_used);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("bisection_cubic_root_finder_unit: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_iteration_limits();
        test_random_intervals();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("bisection_cubic_root_finder_unit: match");
        else
            $display("bisection_cubic_root_finder_unit: mismatch");
        $finish;
    end

endmodule
